// ===== hw/rtl/gsd_pkg.sv =====
// Shared types, codes and constants of the gyro stillness detector.
package gsd_pkg;

   localparam int Axes = 3;
   localparam int RateW = 16;
   localparam int ValW = 18;
   localparam int StampW = 32;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW = 16;

   // Default sizes handed down from the top level
   localparam int WindowSamplesDefault = 10;
   localparam int DwellMsDefault = 100;
   localparam int QueueDepthDefault = 4;

   // Command codes
   localparam logic CmdStart = 1'b0;
   localparam logic CmdSample = 1'b1;

   // Status codes
   localparam logic [1:0] StatusIdle = 2'd0;
   localparam logic [1:0] StatusWaiting = 2'd1;
   localparam logic [1:0] StatusStill = 2'd2;
   localparam logic [1:0] StatusTimeout = 2'd3;

   // Register indexes
   localparam logic [CsrIndexW-1:0] RegMotionTarget = 3'd0;
   localparam logic [CsrIndexW-1:0] RegNoiseFloor = 3'd1;
   localparam logic [CsrIndexW-1:0] RegRateScale = 3'd2;
   localparam logic [CsrIndexW-1:0] RegOffsetX = 3'd3;
   localparam logic [CsrIndexW-1:0] RegOffsetY = 3'd4;
   localparam logic [CsrIndexW-1:0] RegOffsetZ = 3'd5;
   localparam logic [CsrIndexW-1:0] RegTimeoutMs = 3'd6;

   // Register reset values
   localparam logic [15:0] MotionTargetReset = 16'd0;
   localparam logic [15:0] NoiseFloorReset = 16'd20;
   localparam logic [14:0] RateScaleReset = 15'd25000;
   localparam logic [15:0] TimeoutMsReset = 16'd1000;

   // Range map: raw + offset is biased by half scale, divided by 65535
   localparam logic [17:0] RateBias = 18'd32768;
   localparam int DivBase = 65535;

   // x / 5 == (x * DivFiveMul) >> DivFiveShift for x below 2**19
   localparam int DivFiveInW = 19;
   localparam logic [19:0] DivFiveMul = 20'd838861;
   localparam int DivFiveShift = 22;

   typedef struct packed {
      logic [15:0] motion_target;
      logic [15:0] noise_floor;
      logic [14:0] rate_scale;
      logic [Axes-1:0][RateW-1:0] offset;
      logic [15:0] timeout_ms;
   } cfg_type;

   // One mapped sample travelling from the front end to the back end
   typedef struct packed {
      logic command;
      logic [Axes-1:0][ValW-1:0] g;
      logic [StampW-1:0] now_ms;
   } item_type;

endpackage

// ===== hw/rtl/gsd_front.sv =====
// Front end: accepts raw samples and range-maps each axis in two stages.
module gsd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  gsd_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_command,
   input  logic signed [15:0]         req_rate_x,
   input  logic signed [15:0]         req_rate_y,
   input  logic signed [15:0]         req_rate_z,
   input  logic [31:0]                req_now_ms,
   input  logic                       q_full,
   output logic                       q_push,
   output gsd_pkg::item_type          q_item
);

   logic [gsd_pkg::Axes-1:0][gsd_pkg::RateW-1:0] raw;
   logic                     advance;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_cmd_ff;
   logic [31:0]              s1_now_ff;
   logic [gsd_pkg::Axes-1:0] s1_neg_ff, s1_neg_in;
   logic [32:0]              s1_prod_ff [gsd_pkg::Axes];
   logic [32:0]              s1_prod_in [gsd_pkg::Axes];

   logic                     s2_valid_ff, s2_valid_in;
   gsd_pkg::item_type        s2_item_ff, s2_item_in;

   logic [17:0] biased [gsd_pkg::Axes];
   logic [17:0] mag    [gsd_pkg::Axes];
   logic [16:0] hi     [gsd_pkg::Axes];
   logic [17:0] part   [gsd_pkg::Axes];
   logic [1:0]  fix    [gsd_pkg::Axes];
   logic [16:0] quo    [gsd_pkg::Axes];
   logic [18:0] sq     [gsd_pkg::Axes];
   logic [18:0] gval   [gsd_pkg::Axes];
   logic [15:0] scale2;

   assign raw[0] = req_rate_x;
   assign raw[1] = req_rate_y;
   assign raw[2] = req_rate_z;
   assign scale2 = {cfg.rate_scale, 1'b0};

   // Both stages hold only when the queue cannot take the stage 2 transaction
   assign advance = !(s2_valid_ff && q_full);
   assign req_ready = advance;
   assign q_push = s2_valid_ff && !q_full;
   assign q_item = s2_item_ff;

   // Stage 1: bias, magnitude and the 17x16 product
   always_comb begin
      s1_valid_in = req_valid;
      for (int i = 0; i < gsd_pkg::Axes; i++) begin
         biased[i] = {{2{raw[i][15]}}, raw[i]} + {{2{cfg.offset[i][15]}}, cfg.offset[i]}
                     + gsd_pkg::RateBias;
         s1_neg_in[i] = biased[i][17];
         mag[i] = biased[i][17] ? 18'(-biased[i]) : biased[i];
         s1_prod_in[i] = 33'(mag[i][16:0]) * 33'(scale2);
      end
   end

   // Stage 2: p / 65535 = hi + (hi + lo) / 65535, the second term at most 3
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_item_in.command = s1_cmd_ff;
      s2_item_in.now_ms = s1_now_ff;
      for (int i = 0; i < gsd_pkg::Axes; i++) begin
         hi[i] = s1_prod_ff[i][32:16];
         part[i] = {1'b0, hi[i]} + {2'b00, s1_prod_ff[i][15:0]};
         if (part[i] >= 18'(3 * gsd_pkg::DivBase)) begin
            fix[i] = 2'd3;
         end else if (part[i] >= 18'(2 * gsd_pkg::DivBase)) begin
            fix[i] = 2'd2;
         end else if (part[i] >= 18'(gsd_pkg::DivBase)) begin
            fix[i] = 2'd1;
         end else begin
            fix[i] = 2'd0;
         end
         quo[i] = hi[i] + {15'd0, fix[i]};
         sq[i] = s1_neg_ff[i] ? 19'(-{2'b00, quo[i]}) : {2'b00, quo[i]};
         gval[i] = sq[i] - {4'd0, cfg.rate_scale};
         s2_item_in.g[i] = gval[i][17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff <= req_command;
         s1_now_ff <= req_now_ms;
         s1_neg_ff <= s1_neg_in;
         s1_prod_ff <= s1_prod_in;
         s2_item_ff <= s2_item_in;
      end
   end

endmodule

// ===== hw/rtl/gsd_queue.sv =====
// Short FIFO of mapped samples between the front and back ends.
module gsd_queue #(
   parameter int DEPTH = gsd_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gsd_pkg::item_type push_item,
   input  logic              pop,
   output gsd_pkg::item_type head,
   output logic              full,
   output logic              empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   gsd_pkg::item_type entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/gsd_back.sv =====
// Back end: running averages, window tracking, stillness and timeout decisions.
module gsd_back #(
   parameter int WINDOW_SAMPLES = gsd_pkg::WindowSamplesDefault,
   parameter int DWELL_MS = gsd_pkg::DwellMsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  gsd_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  gsd_pkg::item_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_window_done
);

   localparam int CntW = $clog2(WINDOW_SAMPLES + 1);
   localparam int VW = gsd_pkg::ValW;

   logic advance;

   // Average stage
   logic           b1_valid_ff;
   logic           b1_cmd_ff;
   logic [31:0]    b1_now_ff;
   logic [VW-1:0]  avg_ff [gsd_pkg::Axes];
   logic [VW-1:0]  avg_in [gsd_pkg::Axes];
   logic [20:0]    sum    [gsd_pkg::Axes];
   logic [20:0]    mag    [gsd_pkg::Axes];
   logic [38:0]    prod   [gsd_pkg::Axes];
   logic [16:0]    quo    [gsd_pkg::Axes];

   // Window state
   logic [VW-1:0]   min_ff [gsd_pkg::Axes];
   logic [VW-1:0]   min_in [gsd_pkg::Axes];
   logic [VW-1:0]   max_ff [gsd_pkg::Axes];
   logic [VW-1:0]   max_in [gsd_pkg::Axes];
   logic [VW-1:0]   new_min [gsd_pkg::Axes];
   logic [VW-1:0]   new_max [gsd_pkg::Axes];
   logic [VW:0]     span [gsd_pkg::Axes];
   logic [CntW-1:0] count_ff, count_in, count_next;
   logic [31:0]     deadline_ff, deadline_in;
   logic [31:0]     start_ff, start_in;
   logic            active_ff, active_in;

   logic [15:0]     thr;
   logic            quiet;
   logic            still;
   logic            in_time;
   logic [31:0]     elapsed;
   logic [VW-1:0]   open_min, open_max;

   // Result register
   logic            rsp_valid_ff;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic            rsp_done_ff, rsp_done_in;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop = advance && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_window_done = rsp_done_ff;

   // avg = (4*avg + g) / 5 toward zero; seeded by a start transaction.
   // Idle samples update it too: nothing reads it before the next start.
   always_comb begin
      for (int i = 0; i < gsd_pkg::Axes; i++) begin
         sum[i] = {avg_ff[i][VW-1], avg_ff[i], 2'b00}
                  + {{3{q_head.g[i][VW-1]}}, q_head.g[i]};
         mag[i] = sum[i][20] ? 21'(-sum[i]) : sum[i];
         prod[i] = 39'(mag[i][gsd_pkg::DivFiveInW-1:0]) * 39'(gsd_pkg::DivFiveMul);
         quo[i] = prod[i][gsd_pkg::DivFiveShift +: 17];
         if (q_head.command == gsd_pkg::CmdStart) begin
            avg_in[i] = q_head.g[i];
         end else begin
            avg_in[i] = sum[i][20] ? VW'(-{1'b0, quo[i]}) : {1'b0, quo[i]};
         end
      end
   end

   // Window tracking and decisions for the transaction in the average stage
   always_comb begin
      thr = (cfg.motion_target > cfg.noise_floor) ? cfg.motion_target : cfg.noise_floor;
      open_min = {3'b000, cfg.rate_scale};
      open_max = VW'(-{3'b000, cfg.rate_scale});
      quiet = 1'b1;
      for (int i = 0; i < gsd_pkg::Axes; i++) begin
         new_min[i] = ($signed(avg_ff[i]) < $signed(min_ff[i])) ? avg_ff[i] : min_ff[i];
         new_max[i] = ($signed(avg_ff[i]) > $signed(max_ff[i])) ? avg_ff[i] : max_ff[i];
         span[i] = {new_max[i][VW-1], new_max[i]} - {new_min[i][VW-1], new_min[i]};
         if (!($signed(span[i]) < $signed({3'b000, thr}))) begin
            quiet = 1'b0;
         end
      end
      elapsed = b1_now_ff - start_ff;
      in_time = elapsed < {16'd0, cfg.timeout_ms};
      count_next = count_ff + 1'b1;
      still = 1'b0;

      min_in = min_ff;
      max_in = max_ff;
      count_in = count_ff;
      deadline_in = deadline_ff;
      start_in = start_ff;
      active_in = active_ff;
      rsp_status_in = gsd_pkg::StatusIdle;
      rsp_done_in = 1'b0;

      case (b1_cmd_ff)
         gsd_pkg::CmdStart: begin
            start_in = b1_now_ff;
            deadline_in = '0;
            count_in = '0;
            for (int i = 0; i < gsd_pkg::Axes; i++) begin
               min_in[i] = open_min;
               max_in[i] = open_max;
            end
            // elapsed is zero at start, so only a zero timeout expires here
            if (cfg.timeout_ms != '0) begin
               active_in = 1'b1;
               rsp_status_in = gsd_pkg::StatusWaiting;
            end else begin
               active_in = 1'b0;
               rsp_status_in = gsd_pkg::StatusTimeout;
            end
         end
         gsd_pkg::CmdSample: begin
            if (active_ff) begin
               min_in = new_min;
               max_in = new_max;
               count_in = count_next;
               rsp_status_in = gsd_pkg::StatusWaiting;
               if (count_next >= CntW'(WINDOW_SAMPLES)) begin
                  rsp_done_in = 1'b1;
                  if (quiet) begin
                     if (deadline_ff == '0) begin
                        deadline_in = b1_now_ff + 32'(DWELL_MS);
                     end else if (b1_now_ff > deadline_ff) begin
                        still = 1'b1;
                     end
                  end else begin
                     deadline_in = '0;
                  end
                  if (still) begin
                     rsp_status_in = gsd_pkg::StatusStill;
                     active_in = 1'b0;
                  end else if (!in_time) begin
                     rsp_status_in = gsd_pkg::StatusTimeout;
                     active_in = 1'b0;
                  end else begin
                     count_in = '0;
                     for (int i = 0; i < gsd_pkg::Axes; i++) begin
                        min_in[i] = open_min;
                        max_in[i] = open_max;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         deadline_ff <= '0;
         start_ff <= '0;
         active_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff <= !q_empty;
         rsp_valid_ff <= b1_valid_ff;
         if (b1_valid_ff) begin
            count_ff <= count_in;
            deadline_ff <= deadline_in;
            start_ff <= start_in;
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_cmd_ff <= q_head.command;
         b1_now_ff <= q_head.now_ms;
         avg_ff <= avg_in;
      end
      if (advance && b1_valid_ff) begin
         min_ff <= min_in;
         max_ff <= max_in;
         rsp_status_ff <= rsp_status_in;
         rsp_done_ff <= rsp_done_in;
      end
   end

endmodule

// ===== hw/rtl/gyro_stillness_detector_unit.sv =====
// Top level of the gyro stillness detector: register file and front/queue/back.
//
// Samples enter on the req_ channel (valid/ready): a command, three raw signed
// rates and a millisecond timestamp. A start command seeds the running averages
// and starts a wait; regular samples are averaged and checked per window.
// Every accepted transaction yields exactly one rsp_ transaction carrying the
// status (idle, waiting, still, timed out) and whether it closed a window.
// One sample per cycle is sustained while rsp_ready stays high; a response passes
// the two range-map stages, the queue, the average stage and the result register.
// The average recurrence (multiply by the reciprocal of 5) closes through the single
// avg_ff register, which sets that rate.
// When rsp_ready is low the back end holds; the front end keeps taking samples
// until the queue fills, then drops req_ready.
// csr_ writes take effect at the next edge; the user makes them only while idle,
// not enforced by the block. Synchronous reset empties the pipeline, ends any
// wait and loads the register defaults (noise floor 20, scale 25000, timeout 1000 ms).
module gyro_stillness_detector_unit #(
   parameter int WINDOW_SAMPLES = gsd_pkg::WindowSamplesDefault,
   parameter int DWELL_MS = gsd_pkg::DwellMsDefault,
   parameter int QUEUE_DEPTH = gsd_pkg::QueueDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic signed [15:0]             req_rate_x,
   input  logic signed [15:0]             req_rate_y,
   input  logic signed [15:0]             req_rate_z,
   input  logic [31:0]                    req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_window_done,
   input  logic                           csr_write,
   input  logic [gsd_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [gsd_pkg::CsrDataW-1:0]   csr_data
);

   gsd_pkg::cfg_type  cfg_ff, cfg_in;
   logic              q_push, q_pop, q_full, q_empty;
   gsd_pkg::item_type q_item, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            gsd_pkg::RegMotionTarget: cfg_in.motion_target = csr_data;
            gsd_pkg::RegNoiseFloor:   cfg_in.noise_floor = csr_data;
            gsd_pkg::RegRateScale:    cfg_in.rate_scale = csr_data[14:0];
            gsd_pkg::RegOffsetX:      cfg_in.offset[0] = csr_data;
            gsd_pkg::RegOffsetY:      cfg_in.offset[1] = csr_data;
            gsd_pkg::RegOffsetZ:      cfg_in.offset[2] = csr_data;
            gsd_pkg::RegTimeoutMs:    cfg_in.timeout_ms = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_target <= gsd_pkg::MotionTargetReset;
         cfg_ff.noise_floor <= gsd_pkg::NoiseFloorReset;
         cfg_ff.rate_scale <= gsd_pkg::RateScaleReset;
         cfg_ff.offset <= '0;
         cfg_ff.timeout_ms <= gsd_pkg::TimeoutMsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_rate_x  (req_rate_x),
      .req_rate_y  (req_rate_y),
      .req_rate_z  (req_rate_z),
      .req_now_ms  (req_now_ms),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   gsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   gsd_back #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES),
      .DWELL_MS       (DWELL_MS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_window_done (rsp_window_done)
   );

endmodule

// ===== hw/rtl/gsd_checker.sv =====
// Port-level checks of the gyro stillness detector, bound to the top level.
module gsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_window_done
);

   // A stalled response holds its payload
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_window_done))
      else $error("response changed while stalled");

   // Idle transactions never close a window
   idle_no_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gsd_pkg::StatusIdle |-> !rsp_window_done)
      else $error("idle response marked window done");

   // Stillness is only ever reported at a window end
   still_at_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gsd_pkg::StatusStill |-> rsp_window_done)
      else $error("stillness reported mid-window");

   // Reset leaves no response pending
   reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind gyro_stillness_detector_unit gsd_checker u_gsd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_window_done (rsp_window_done)
);

// ===== verif/stillness_checker.sv =====
// Response checker for the gyro stillness detector: predicts each response and compares.
module stillness_checker #(
   parameter int WindowSamples = gsd_pkg::WindowSamplesDefault,
   parameter int DwellMs = gsd_pkg::DwellMsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_command,
   input  logic signed [15:0]             req_rate_x,
   input  logic signed [15:0]             req_rate_y,
   input  logic signed [15:0]             req_rate_z,
   input  logic [31:0]                    req_now_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [1:0]                     rsp_status,
   input  logic                           rsp_window_done,
   input  logic                           csr_write,
   input  logic [gsd_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [gsd_pkg::CsrDataW-1:0]   csr_data,
   output int                             mismatch_count,
   output int                             pending_count
);
   import gsd_pkg::*;

   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [1:0] status;
      logic       window_done;
   } step_result_type;

   // Shadow of the register file
   logic [15:0] motion_target;
   logic [15:0] noise_floor;
   logic [14:0] rate_scale;
   logic signed [15:0] offset [Axes];
   logic [15:0] timeout_ms;

   // Predicted detector state
   int avg [Axes];
   int win_lo [Axes];
   int win_hi [Axes];
   int samples_in_window;
   logic [31:0] dwell_deadline;
   logic [31:0] wait_start;
   logic waiting;

   step_result_type expected_status_q [$];
   step_result_type want;

   function automatic int map_rate(logic signed [15:0] raw, logic signed [15:0] offs);
      longint biased;
      longint scale;
      biased = longint'(raw) + longint'(offs) + 64'sd32768;
      scale = longint'(rate_scale);
      return int'((biased * 2 * scale) / DivBase - scale);
   endfunction

   function automatic void restart_window();
      for (int i = 0; i < Axes; i++) begin
         win_lo[i] = int'(rate_scale);
         win_hi[i] = -int'(rate_scale);
      end
      samples_in_window = 0;
   endfunction

   function automatic step_result_type advance_stillness(logic cmd, logic signed [15:0] rx,
                                                         logic signed [15:0] ry,
                                                         logic signed [15:0] rz,
                                                         logic [31:0] now);
      step_result_type res;
      int g [Axes];
      int thr;
      logic [31:0] elapsed;
      logic quiet;
      logic still;
      res.status = StatusIdle;
      res.window_done = 1'b0;
      g[0] = map_rate(rx, offset[0]);
      g[1] = map_rate(ry, offset[1]);
      g[2] = map_rate(rz, offset[2]);
      if (cmd == CmdStart) begin
         for (int i = 0; i < Axes; i++) avg[i] = g[i];
         wait_start = now;
         dwell_deadline = '0;
         restart_window();
         elapsed = now - wait_start;
         // only a zero timeout can expire right at start
         if (elapsed < 32'(timeout_ms)) begin
            waiting = 1'b1;
            res.status = StatusWaiting;
         end else begin
            waiting = 1'b0;
            res.status = StatusTimeout;
         end
      end else if (waiting) begin
         for (int i = 0; i < Axes; i++) begin
            avg[i] = (4 * avg[i] + g[i]) / 5;
            if (avg[i] < win_lo[i]) win_lo[i] = avg[i];
            if (avg[i] > win_hi[i]) win_hi[i] = avg[i];
         end
         samples_in_window++;
         res.status = StatusWaiting;
         if (samples_in_window >= WindowSamples) begin
            thr = (motion_target > noise_floor) ? int'(motion_target) : int'(noise_floor);
            quiet = 1'b1;
            still = 1'b0;
            res.window_done = 1'b1;
            for (int i = 0; i < Axes; i++)
               if (!(win_hi[i] - win_lo[i] < thr)) quiet = 1'b0;
            // a deadline that wraps to zero reads as unarmed
            if (quiet) begin
               if (dwell_deadline == '0) dwell_deadline = now + 32'(DwellMs);
               else if (now > dwell_deadline) still = 1'b1;
            end else begin
               dwell_deadline = '0;
            end
            elapsed = now - wait_start;
            if (still) begin
               res.status = StatusStill;
               waiting = 1'b0;
            end else if (!(elapsed < 32'(timeout_ms))) begin
               res.status = StatusTimeout;
               waiting = 1'b0;
            end else begin
               restart_window();
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         motion_target = MotionTargetReset;
         noise_floor = NoiseFloorReset;
         rate_scale = RateScaleReset;
         timeout_ms = TimeoutMsReset;
         for (int i = 0; i < Axes; i++) begin
            offset[i] = '0;
            avg[i] = 0;
            win_lo[i] = 0;
            win_hi[i] = 0;
         end
         samples_in_window = 0;
         dwell_deadline = '0;
         wait_start = '0;
         waiting = 1'b0;
         mismatch_count = 0;
         expected_status_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_status_q.push_back(advance_stillness(req_command, req_rate_x, req_rate_y,
                                                          req_rate_z, req_now_ms));
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               if (mismatch_count < ReportLimit)
                  $display("%0t stillness_checker: unexpected response status %0d window_done %0b",
                           $time, rsp_status, rsp_window_done);
               mismatch_count++;
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_status !== want.status || rsp_window_done !== want.window_done) begin
                  if (mismatch_count < ReportLimit)
                     $display({"%0t stillness_checker: expected status %0d window_done %0b,",
                               " got %0d %0b"},
                              $time, want.status, want.window_done, rsp_status, rsp_window_done);
                  mismatch_count++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               RegMotionTarget: motion_target = csr_data;
               RegNoiseFloor: noise_floor = csr_data;
               RegRateScale: rate_scale = csr_data[14:0];
               RegOffsetX: offset[0] = csr_data;
               RegOffsetY: offset[1] = csr_data;
               RegOffsetZ: offset[2] = csr_data;
               RegTimeoutMs: timeout_ms = csr_data;
               default: ;
            endcase
         end
      end
      pending_count = expected_status_q.size();
   end

endmodule

// ===== verif/gyro_stillness_detector_unit_tb.sv =====
// Testbench top for the gyro stillness detector: stimulus, handshakes and verdict.
module gyro_stillness_detector_unit_tb;
   import gsd_pkg::*;

   localparam int HoldOffCycles = 60;
   localparam int DrainCycles = 12;
   localparam int PhaseItems = 85;
   localparam int RandomPhases = 8;
   localparam int RunLimit = 6_000_000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_command;
   logic signed [15:0] req_rate_x;
   logic signed [15:0] req_rate_y;
   logic signed [15:0] req_rate_z;
   logic [31:0] req_now_ms;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_status;
   logic rsp_window_done;
   logic csr_write;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_data;
   int mismatch_count;
   int pending_count;

   logic calm;          // no gaps on either side
   logic hold_off_req;  // asks the receiver for one long stall
   logic hold_off_done; // receiver has served the long stall
   int stall_left;
   int phase_items;

   gyro_stillness_detector_unit i_dut (.*);

   stillness_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #(RunLimit);
      $display("[gyro_stillness_detector_unit] ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // base plus uniform jitter, clamped to the raw range
   function automatic logic signed [15:0] near(logic signed [15:0] base, int amp);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   function automatic logic [15:0] pick_setting(int lo, int hi, int dflt, int typical_hi);
      int v;
      case ($urandom_range(0, 7))
         0: v = lo;
         1: v = hi;
         2: v = dflt;
         default: v = lo + int'($urandom_range(0, typical_hi - lo));
      endcase
      return 16'(v);
   endfunction

   task automatic send(logic cmd, logic signed [15:0] rx, logic signed [15:0] ry,
                       logic signed [15:0] rz, logic [31:0] stamp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_rate_x = rx;
      req_rate_y = ry;
      req_rate_z = rz;
      req_now_ms = stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      phase_items++;
   endtask

   // stop offering and wait for every outstanding response
   task automatic settle();
      req_valid = 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(logic [CsrIndexW-1:0] idx, logic [15:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
   endtask

   // one wait: a start transaction followed by a run of samples
   task automatic run_wait();
      int kind;
      int count;
      int step;
      int amp;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic [31:0] stamp;
      kind = $urandom_range(0, 99);
      step = $urandom_range(1, 40);
      amp = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 4);
      count = (kind >= 90) ? $urandom_range(0, 9) : $urandom_range(12, 45);
      bx = 16'($urandom);
      by = 16'($urandom);
      bz = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         bx = 16'sh7FFF;
         bz = 16'sh8000;
      end
      if (kind < 8) begin
         // first window closes exactly where the dwell deadline wraps to zero
         amp = 0;
         stamp = 32'd0 - 32'(DwellMsDefault) - 32'(WindowSamplesDefault * step);
      end else begin
         case ($urandom_range(0, 3))
            0: stamp = 32'($urandom_range(0, 5000));
            1: stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
            default: stamp = $urandom;
         endcase
      end
      send(CmdStart, near(bx, amp), near(by, amp), near(bz, amp), stamp);
      for (int i = 0; i < count; i++) begin
         stamp = stamp + 32'(step);
         if (kind >= 8 && $urandom_range(0, 39) == 0)
            stamp = stamp + 32'($urandom_range(100, 3000));
         if ((kind >= 8 && kind < 25) || (kind >= 25 && kind < 35 && $urandom_range(0, 11) == 0))
            send(CmdSample, 16'($urandom), 16'($urandom), 16'($urandom), stamp);
         else
            send(CmdSample, near(bx, amp), near(by, amp), near(bz, amp), stamp);
      end
      if ($urandom_range(0, 9) == 0)
         send(CmdSample, 16'($urandom), 16'($urandom), 16'($urandom), stamp + 32'd5);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      stall_left = 0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_ready = 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
            hold_off_done = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CmdSample;
      req_rate_x = '0;
      req_rate_y = '0;
      req_rate_z = '0;
      req_now_ms = '0;
      csr_write = 1'b0;
      csr_index = RegMotionTarget;
      csr_data = '0;
      calm = 1'b0;
      hold_off_req = 1'b0;
      phase_items = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sample with no wait active
      send(CmdSample, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
      // constant input at the raw minimum: two quiet windows reach stillness
      send(CmdStart, 16'sh8000, 16'sh8000, 16'sh8000, 32'd0);
      for (int i = 1; i <= 2 * WindowSamplesDefault; i++)
         send(CmdSample, 16'sh8000, 16'sh8000, 16'sh8000, 32'(i * 20));
      send(CmdSample, 16'sh1234, 16'shEDCB, 16'sh0000, 32'd420);
      // zero timeout expires on the start transaction itself
      settle();
      write_reg(RegTimeoutMs, 16'd0);
      csr_write = 1'b0;
      send(CmdStart, 16'sh0000, 16'sh0000, 16'sh0000, 32'd500);

      for (int p = 0; p < RandomPhases; p++) begin
         settle();
         case (p)
            0: begin
               write_reg(RegMotionTarget, pick_setting(0, 65535, 0, 300));
               write_reg(RegNoiseFloor, pick_setting(0, 65535, 20, 300));
               write_reg(RegRateScale, pick_setting(1, 32767, 25000, 32767));
               write_reg(RegOffsetX, pick_setting(-32768, 32767, 0, 32767));
               write_reg(RegOffsetY, pick_setting(-32768, 32767, 0, 32767));
               write_reg(RegOffsetZ, pick_setting(-32768, 32767, 0, 32767));
               write_reg(RegTimeoutMs, pick_setting(0, 65535, 1000, 3000));
            end
            1: begin
               write_reg(RegMotionTarget, 16'd0);
               write_reg(RegNoiseFloor, 16'd0);
               write_reg(RegRateScale, 16'd1);
               write_reg(RegOffsetX, 16'h8000);
               write_reg(RegOffsetY, 16'h8000);
               write_reg(RegOffsetZ, 16'h8000);
               write_reg(RegTimeoutMs, 16'd300);
            end
            2: begin
               write_reg(RegMotionTarget, 16'hFFFF);
               write_reg(RegNoiseFloor, 16'hFFFF);
               write_reg(RegRateScale, 16'h7FFF);
               write_reg(RegOffsetX, 16'h7FFF);
               write_reg(RegOffsetY, 16'h7FFF);
               write_reg(RegOffsetZ, 16'h7FFF);
               write_reg(RegTimeoutMs, 16'hFFFF);
            end
            default: begin
               if ($urandom_range(0, 1))
                  write_reg(RegMotionTarget, pick_setting(0, 65535, 0, 300));
               if ($urandom_range(0, 1))
                  write_reg(RegNoiseFloor, pick_setting(0, 65535, 20, 300));
               if ($urandom_range(0, 1))
                  write_reg(RegRateScale, pick_setting(1, 32767, 25000, 32767));
               if ($urandom_range(0, 1))
                  write_reg(RegOffsetX, pick_setting(-32768, 32767, 0, 32767));
               if ($urandom_range(0, 1))
                  write_reg(RegOffsetY, pick_setting(-32768, 32767, 0, 32767));
               if ($urandom_range(0, 1))
                  write_reg(RegOffsetZ, pick_setting(-32768, 32767, 0, 32767));
               if ($urandom_range(0, 1))
                  write_reg(RegTimeoutMs, pick_setting(0, 65535, 1000, 3000));
            end
         endcase
         csr_write = 1'b0;
         // back-to-back transactions while the receiver holds off fill the queue
         if (p == 2) begin
            calm = 1'b1;
            hold_off_req = 1'b1;
         end
         if (p == 5) calm = 1'b1;
         phase_items = 0;
         while (phase_items < PhaseItems) run_wait();
         calm = 1'b0;
      end

      settle();
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[gyro_stillness_detector_unit] OK");
      end else begin
         $display("[gyro_stillness_detector_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== gyro_stillness_detector_unit.f =====
hw/rtl/gsd_pkg.sv
hw/rtl/gsd_front.sv
hw/rtl/gsd_queue.sv
hw/rtl/gsd_back.sv
hw/rtl/gyro_stillness_detector_unit.sv
hw/rtl/gsd_checker.sv
verif/stillness_checker.sv
verif/gyro_stillness_detector_unit_tb.sv
